// ----- hw/rtl/nearest_rank_percentile_store_top_assert.svh -----
// assertion macros for the percentile store checker
`ifndef NEAREST_RANK_PERCENTILE_STORE_TOP_ASSERT_SVH
`define NEAREST_RANK_PERCENTILE_STORE_TOP_ASSERT_SVH

// same-cycle implication
`define NRPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nrps assertion failed");

// next-cycle implication
`define NRPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nrps assertion failed");

`endif

// ----- hw/rtl/nrps_pkg.sv -----
package nrps_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int VAL_W    = 32;
    localparam int FRAC_W   = 17;
    localparam int GRP      = 8;
    localparam int GROUPS   = (CAPACITY + GRP - 1) / GRP;

    localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic
    {
        FUNC_INSERT = 1'b0,
        FUNC_QUERY  = 1'b1
    } func_t;

    typedef logic signed [VAL_W-1:0] value_t;

    typedef struct packed
    {
        func_t             func;
        value_t            sample;
        logic [FRAC_W-1:0] fraction;
    } in_t;

    typedef struct packed
    {
        value_t answer;
        logic   found;
        logic   overflow;
    } out_t;

    typedef struct packed
    {
        logic             ins;
        value_t           sample;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] rank;
    } cell_ctl_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_GATHER,
        S_REDUCE
    } state_t;

endpackage

// ----- hw/rtl/nearest_rank_percentile_store_top.sv -----
// Sorted store of up to CAPACITY signed Q16.16 samples with nearest-rank
// percentile lookup.
// Input channel in_valid / in_ready / in_data: func selects insert or query.
// Output channel out_valid / out_ready / out_data: one result per input transfer.
// An insert is placed by a row of compare-and-shift cells at the transfer edge; its
// result appears in the cycle after the transfer, so inserts run at one per cycle
// while the receiver takes results. A full store drops the sample and reports
// overflow.
// A query multiplies the fraction by the count on the transfer edge, then reads
// the selected cell through a two-level OR tree whose first level is registered
// in S_GATHER; S_REDUCE registers the result, and the next transfer can follow it.
// Reset clears the count (the store reads as empty) and the control state;
// the sample cells themselves are not cleared.
// When the receiver stalls, the result waits in the output register and no
// new item is taken until that register is drained or drains the same cycle.
module nearest_rank_percentile_store_top
    import nrps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] rank_reg;
    logic [IDX_W-1:0] rank_next;
    logic             qfound_reg;
    logic             qfound_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_t             out_reg;
    out_t             out_next;

    logic                    accept;
    logic                    is_ins;
    logic                    full;
    logic [FRAC_W-1:0]       frac_sat;
    logic [FRAC_W+CNT_W-1:0] prod;
    logic [FRAC_W+CNT_W:0]   prod_up;
    logic [CNT_W+1:0]        up;
    logic [CNT_W+1:0]        up_m1;
    logic [IDX_W-1:0]        rank_calc;
    cell_ctl_t               ctl;
    value_t                  selected;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign is_ins   = (in_data.func == FUNC_INSERT);
    assign full     = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        frac_sat  = (in_data.fraction > ONE_Q16) ? ONE_Q16 : in_data.fraction;
        prod      = (FRAC_W+CNT_W)'(frac_sat) * (FRAC_W+CNT_W)'(count_reg);
        prod_up   = (FRAC_W+CNT_W+1)'(prod) + (FRAC_W+CNT_W+1)'(ONE_Q16 - 1'b1);
        up        = prod_up[FRAC_W+CNT_W:16];
        up_m1     = up - (CNT_W+2)'(1);
        rank_calc = (up == '0) ? '0 : up_m1[IDX_W-1:0];
    end

    always_comb
    begin
        ctl.ins    = accept && is_ins && !full;
        ctl.sample = in_data.sample;
        ctl.count  = count_reg;
        ctl.rank   = rank_reg;
    end

    nrps_chain u_chain
    (
        .clk      (clk),
        .ctl      (ctl),
        .selected (selected)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rank_next      = rank_reg;
        qfound_next    = qfound_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_ins)
                    begin
                        out_next.answer   = '0;
                        out_next.found    = 1'b0;
                        out_next.overflow = full;
                        out_valid_next    = 1'b1;
                        if (!full)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        rank_next   = rank_calc;
                        qfound_next = (count_reg != '0);
                        state_next  = S_GATHER;
                    end
                end
            end
            S_GATHER:
            begin
                state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                out_next.answer   = qfound_reg ? selected : '0;
                out_next.found    = qfound_reg;
                out_next.overflow = 1'b0;
                out_valid_next    = 1'b1;
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg   <= rank_next;
        qfound_reg <= qfound_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- hw/rtl/nrps_cell.sv -----
module nrps_cell
    import nrps_pkg::*;
(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic [IDX_W-1:0] idx,
    input  value_t           left_val,
    input  logic             left_take,
    output value_t           val,
    output logic             take,
    output value_t           sel
);

    value_t val_reg;
    value_t val_next;
    logic   held;

    always_comb
    begin
        held = CNT_W'(idx) < ctl.count;
        take = !held || (val_reg > ctl.sample);
        val_next = val_reg;
        if (ctl.ins)
        begin
            if (left_take)
            begin
                val_next = left_val;
            end
            else if (take)
            begin
                val_next = ctl.sample;
            end
        end
        sel = (idx == ctl.rank) ? val_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ----- hw/rtl/nrps_chain.sv -----
module nrps_chain
    import nrps_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    output value_t    selected
);

    value_t cell_val  [CAPACITY];
    logic   cell_take [CAPACITY];
    value_t cell_sel  [CAPACITY];
    value_t group_reg [GROUPS];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        value_t left_val;
        logic   left_take;

        if (i == 0)
        begin : g_head
            assign left_val  = '0;
            assign left_take = 1'b0;
        end
        else
        begin : g_body
            assign left_val  = cell_val[i-1];
            assign left_take = cell_take[i-1];
        end

        nrps_cell u_cell
        (
            .clk       (clk),
            .ctl       (ctl),
            .idx       (IDX_W'(i)),
            .left_val  (left_val),
            .left_take (left_take),
            .val       (cell_val[i]),
            .take      (cell_take[i]),
            .sel       (cell_sel[i])
        );
    end

    // first level of the read tree
    for (genvar g = 0; g < GROUPS; g++)
    begin : g_group
        value_t group_or;

        always_comb
        begin
            group_or = '0;
            for (int j = 0; j < GRP; j++)
            begin
                if (g * GRP + j < CAPACITY)
                begin
                    group_or = group_or | cell_sel[g * GRP + j];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            group_reg[g] <= group_or;
        end
    end

    always_comb
    begin
        selected = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            selected = selected | group_reg[g];
        end
    end

endmodule

// ----- hw/rtl/nrps_check.sv -----
`include "nearest_rank_percentile_store_top_assert.svh"

module nrps_check
    import nrps_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_data,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    `NRPS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `NRPS_ASSERT_IMP(a_flags_excl, clk, rst_n, out_valid, !(out_data.found && out_data.overflow))
    `NRPS_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && !out_data.found, out_data.answer == '0)
    `NRPS_ASSERT_NXT(a_insert_result, clk, rst_n, in_valid && in_ready && in_data.func == FUNC_INSERT, out_valid && !out_data.found)
    `NRPS_ASSERT_IMP(a_query_result, clk, rst_n, $past(rst_n && in_valid && in_ready && in_data.func == FUNC_QUERY, 3), out_valid && !out_data.overflow)

endmodule

bind nearest_rank_percentile_store_top nrps_check u_nrps_check
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
